@@ hw/rtl/deficit_rr_priority_dispatcher_defines.svh @@
// Assertion macros for the deficit round-robin dispatcher.
`ifndef DEFICIT_RR_PRIORITY_DISPATCHER_DEFINES_SVH
`define DEFICIT_RR_PRIORITY_DISPATCHER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DRR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define DRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/dwrr_pkg.sv @@
// Shared types and constants for the deficit round-robin dispatcher.
`default_nettype none
package dwrr_pkg;

	localparam int CLASSES_DEF     = 4;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TAG_COUNT_DEF   = 128;

	localparam int REG_WEIGHT0      = 0;
	localparam int REG_MAX_INFLIGHT = 4;

	typedef enum logic [1:0] {
		CMD_ENQ  = 2'd0,
		CMD_DISP = 2'd1,
		CMD_DONE = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_TAG_BUSY = 2'd2,
		ST_NONE     = 2'd3
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic exec;   // take the transaction on the input ports this edge
		logic resp;   // result cycle
	} ctl_cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/dwrr_ctrl.sv @@
// Controller state machine: accept, then one result cycle.
`default_nettype none
module dwrr_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	output logic                    done,
	output dwrr_pkg::ctl_cmd_t      ctl
);

	typedef enum logic {
		S_IDLE,
		S_RESP
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_RESP;
				end
				S_RESP: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q == S_RESP);
	assign done     = (state_q == S_RESP);
	assign ctl.exec = start && (state_q == S_IDLE);
	assign ctl.resp = (state_q == S_RESP);

endmodule
`default_nettype wire

@@ hw/rtl/dwrr_datapath.sv @@
// Datapath: class FIFOs, credits, tag maps, in-flight table.
`default_nettype none
module dwrr_datapath #(
	parameter int CLASSES     = dwrr_pkg::CLASSES_DEF,
	parameter int QUEUE_DEPTH = dwrr_pkg::QUEUE_DEPTH_DEF,
	parameter int TAG_COUNT   = dwrr_pkg::TAG_COUNT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  dwrr_pkg::ctl_cmd_t      ctl,
	input  wire logic [1:0]         cmd,
	input  wire logic [1:0]         req_priority,
	input  wire logic [31:0]        req_handle,
	input  wire logic [6:0]         done_tag,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [7:0]         cfg_data,
	output logic [1:0]              status,
	output logic [6:0]              out_tag,
	output logic [1:0]              out_class,
	output logic [31:0]             out_handle
);

	localparam int CLW = $clog2(CLASSES);
	localparam int HW  = $clog2(QUEUE_DEPTH);
	localparam int NW  = $clog2(QUEUE_DEPTH + 1);
	localparam int TW  = $clog2(TAG_COUNT);
	localparam int IW  = $clog2(TAG_COUNT + 1);
	localparam int AW  = $clog2(CLASSES * QUEUE_DEPTH);
	localparam int QW  = TW + 32;
	localparam int SLOTS = CLASSES * QUEUE_DEPTH;

	typedef enum logic [1:0] {
		K_PLAIN,
		K_GRANT,
		K_DONE
	} kind_t;

	logic [HW-1:0]  head_q [CLASSES];
	logic [NW-1:0]  cnt_q  [CLASSES];
	logic [7:0]     cred_q [CLASSES];
	logic [CLW-1:0] cursor_q;
	logic [TW-1:0]  next_tag_q;
	logic           live_q [TAG_COUNT];
	logic           infl_q [TAG_COUNT];
	logic [IW-1:0]  icnt_q;
	logic [7:0]     weight_q [4];
	logic [6:0]     maxinf_q;

	kind_t              kind_q;
	dwrr_pkg::status_t  status_q;
	logic [6:0]         tag_q;
	logic [CLW-1:0]     class_q;

	logic [QW-1:0]  qmem [SLOTS];
	logic [33:0]    imem [TAG_COUNT];
	logic [QW-1:0]  qrd_q;
	logic [33:0]    ird_q;

	dwrr_pkg::cmd_t cmd_c;
	logic           pri_ok, full, tag_busy, enq_ok, any_q, disp_try, cmp_ok;
	logic [CLW-1:0] pidx;
	logic [HW+1:0]  tail_sum;
	logic [HW-1:0]  tail_idx;
	logic [AW-1:0]  wr_addr, rd_addr;
	logic [TW-1:0]  dtag;
	logic [TW-1:0]  grant_tag;

	logic [7:0]     cred_fin [CLASSES];
	logic [CLW-1:0] cursor_scan;
	logic           grant;
	logic [CLW-1:0] gp;

	assign cmd_c    = dwrr_pkg::cmd_t'(cmd);
	assign pri_ok   = 32'(req_priority) < CLASSES;
	assign pidx     = CLW'(req_priority);
	assign full     = !pri_ok || (32'(cnt_q[pidx]) >= QUEUE_DEPTH);
	assign tag_busy = live_q[next_tag_q];
	assign enq_ok   = !full && !tag_busy;
	assign dtag     = TW'(done_tag);
	assign cmp_ok   = (32'(done_tag) < TAG_COUNT) && infl_q[dtag];
	assign grant_tag = qrd_q[QW-1:32];

	always_comb begin
		any_q = 1'b0;
		for (int i = 0; i < CLASSES; i++) begin
			if (cnt_q[i] != '0) any_q = 1'b1;
		end
	end

	assign disp_try = (32'(icnt_q) < 32'(maxinf_q)) && any_q;

	// tail slot: (head + count) mod depth
	assign tail_sum = (HW+2)'(head_q[pidx]) + (HW+2)'(cnt_q[pidx]);
	assign tail_idx = (32'(tail_sum) >= QUEUE_DEPTH) ?
		HW'(32'(tail_sum) - QUEUE_DEPTH) : HW'(tail_sum);
	assign wr_addr  = AW'(32'(pidx) * QUEUE_DEPTH + 32'(tail_idx));
	assign rd_addr  = AW'(32'(gp) * QUEUE_DEPTH + 32'(head_q[gp]));

	// replenish, then scan from the cursor
	always_comb begin
		logic           ready;
		logic [8:0]     sum;
		logic [CLW-1:0] cur;
		logic [CLW-1:0] p;
		logic           found;
		ready = 1'b0;
		sum   = '0;
		found = 1'b0;
		gp    = '0;
		for (int i = 0; i < CLASSES; i++) begin
			if (cnt_q[i] != '0 && cred_q[i] != '0) ready = 1'b1;
		end
		for (int i = 0; i < CLASSES; i++) begin
			cred_fin[i] = cred_q[i];
			if (!ready) begin
				if (cnt_q[i] != '0) begin
					sum = 9'(cred_q[i]) + 9'(weight_q[i]);
					cred_fin[i] = sum[8] ? 8'hFF : sum[7:0];
				end else begin
					cred_fin[i] = '0;
				end
			end
		end
		cur = cursor_q;
		for (int i = 0; i < CLASSES; i++) begin
			if (!found) begin
				p   = cur;
				cur = (32'(cur) == CLASSES - 1) ? '0 : cur + 1'b1;
				if (cnt_q[p] == '0) begin
					cred_fin[p] = '0;
				end else if (cred_fin[p] != '0) begin
					cred_fin[p] = cred_fin[p] - 8'd1;
					found = 1'b1;
					gp    = p;
				end
			end
		end
		if (found && cnt_q[gp] == NW'(1)) cred_fin[gp] = '0;
		grant       = found;
		cursor_scan = cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLASSES; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
				cred_q[i] <= '0;
			end
			for (int i = 0; i < TAG_COUNT; i++) begin
				live_q[i] <= 1'b0;
				infl_q[i] <= 1'b0;
			end
			for (int i = 0; i < 4; i++) weight_q[i] <= 8'd1;
			maxinf_q   <= 7'd8;
			cursor_q   <= '0;
			next_tag_q <= '0;
			icnt_q     <= '0;
			kind_q     <= K_PLAIN;
			status_q   <= dwrr_pkg::ST_NONE;
			tag_q      <= '0;
			class_q    <= '0;
		end else begin
			if (cfg_we) begin
				if (32'(cfg_index) < dwrr_pkg::REG_MAX_INFLIGHT)
					weight_q[cfg_index[1:0]] <= cfg_data;
				else if (32'(cfg_index) == dwrr_pkg::REG_MAX_INFLIGHT)
					maxinf_q <= cfg_data[6:0];
			end
			if (ctl.resp && kind_q == K_GRANT) infl_q[grant_tag] <= 1'b1;
			if (ctl.exec) begin
				kind_q   <= K_PLAIN;
				status_q <= dwrr_pkg::ST_NONE;
				tag_q    <= '0;
				case (cmd_c)
					dwrr_pkg::CMD_ENQ: begin
						if (full)          status_q <= dwrr_pkg::ST_FULL;
						else if (tag_busy) status_q <= dwrr_pkg::ST_TAG_BUSY;
						else begin
							status_q       <= dwrr_pkg::ST_OK;
							tag_q          <= 7'(next_tag_q);
							cnt_q[pidx]    <= cnt_q[pidx] + 1'b1;
							live_q[next_tag_q] <= 1'b1;
							next_tag_q <= (32'(next_tag_q) == TAG_COUNT - 1) ?
								'0 : next_tag_q + 1'b1;
						end
					end
					dwrr_pkg::CMD_DISP: begin
						if (disp_try) begin
							for (int i = 0; i < CLASSES; i++) cred_q[i] <= cred_fin[i];
							cursor_q <= cursor_scan;
							if (grant) begin
								kind_q     <= K_GRANT;
								status_q   <= dwrr_pkg::ST_OK;
								class_q    <= gp;
								head_q[gp] <= (32'(head_q[gp]) == QUEUE_DEPTH - 1) ?
									'0 : head_q[gp] + 1'b1;
								cnt_q[gp]  <= cnt_q[gp] - 1'b1;
								icnt_q     <= icnt_q + 1'b1;
							end
						end
					end
					dwrr_pkg::CMD_DONE: begin
						if (cmp_ok) begin
							kind_q       <= K_DONE;
							status_q     <= dwrr_pkg::ST_OK;
							tag_q        <= done_tag;
							infl_q[dtag] <= 1'b0;
							live_q[dtag] <= 1'b0;
							if (icnt_q != '0) icnt_q <= icnt_q - 1'b1;
						end
					end
					default: begin
						kind_q <= K_PLAIN;
					end
				endcase
			end
		end
	end

	// FIFO store and in-flight table, registered reads
	always_ff @(posedge clk) begin
		if (ctl.exec && cmd_c == dwrr_pkg::CMD_ENQ && enq_ok)
			qmem[wr_addr] <= {next_tag_q, req_handle};
		if (ctl.exec) qrd_q <= qmem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.resp && kind_q == K_GRANT)
			imem[grant_tag] <= {2'(class_q), qrd_q[31:0]};
		if (ctl.exec) ird_q <= imem[dtag];
	end

	always_comb begin
		status = status_q;
		case (kind_q)
			K_GRANT: begin
				out_tag    = 7'(grant_tag);
				out_class  = 2'(class_q);
				out_handle = qrd_q[31:0];
			end
			K_DONE: begin
				out_tag    = tag_q;
				out_class  = ird_q[33:32];
				out_handle = ird_q[31:0];
			end
			default: begin
				out_tag    = tag_q;
				out_class  = '0;
				out_handle = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hw/rtl/deficit_rr_priority_dispatcher.sv @@
// Top level of the deficit-weighted round-robin request dispatcher.
//
// Channel   Direction  Handshake              Payload
// command   in         start && !busy         cmd, req_priority, req_handle, done_tag
// result    out        done (one cycle)       status, out_tag, out_class, out_handle
// config    in         cfg_we                 cfg_index, cfg_data
//
// In each transaction the accept edge updates queue pointers, credits and
// tag maps and launches the FIFO or in-flight table read; the next cycle
// presents the result from the registered memory data. busy is high
// during the result cycle, so a new transaction cannot start until the
// result has been presented. The receiver cannot stall. arst_n clears all control
// state; FIFO and in-flight memories need no clearing.
`default_nettype none
`include "deficit_rr_priority_dispatcher_defines.svh"
module deficit_rr_priority_dispatcher #(
	parameter int CLASSES     = dwrr_pkg::CLASSES_DEF,
	parameter int QUEUE_DEPTH = dwrr_pkg::QUEUE_DEPTH_DEF,
	parameter int TAG_COUNT   = dwrr_pkg::TAG_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  cmd,
	input  wire logic [1:0]  req_priority,
	input  wire logic [31:0] req_handle,
	input  wire logic [6:0]  done_tag,
	output logic             done,
	output logic [1:0]       status,
	output logic [6:0]       out_tag,
	output logic [1:0]       out_class,
	output logic [31:0]      out_handle,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	dwrr_pkg::ctl_cmd_t ctl;

	// sequencing
	dwrr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	// queues, credits and tag bookkeeping
	dwrr_datapath #(
		.CLASSES     (CLASSES),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_COUNT   (TAG_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.cmd          (cmd),
		.req_priority (req_priority),
		.req_handle   (req_handle),
		.done_tag     (done_tag),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.status       (status),
		.out_tag      (out_tag),
		.out_class    (out_class),
		.out_handle   (out_handle)
	);

	// every accepted transaction yields exactly one result, next cycle
	`DRR_ASSERT_NEXT(a_accept_gives_result, clk, arst_n, start && !busy, done, "accept without result")
	`DRR_ASSERT_NEXT(a_single_result, clk, arst_n, done, !done, "result repeated")
	`DRR_ASSERT_NOW(a_result_only_busy, clk, arst_n, done, busy, "result while idle")

endmodule
`default_nettype wire

@@ tb/deficit_rr_priority_dispatcher_checker.sv @@
// Checker for the dispatcher: mirrors its queues, credits and tag maps and compares results.
`timescale 1ns / 100ps
`default_nettype none
module deficit_rr_priority_dispatcher_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [1:0]  cmd,
	input  wire logic [1:0]  req_priority,
	input  wire logic [31:0] req_handle,
	input  wire logic [6:0]  done_tag,
	input  wire logic        done,
	input  wire logic [1:0]  status,
	input  wire logic [6:0]  out_tag,
	input  wire logic [1:0]  out_class,
	input  wire logic [31:0] out_handle,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	output int               fail_count,
	output int               pending
);
	localparam int NC = dwrr_pkg::CLASSES_DEF;
	localparam int QD = dwrr_pkg::QUEUE_DEPTH_DEF;
	localparam int NT = dwrr_pkg::TAG_COUNT_DEF;
	localparam int XD = 16;

	typedef struct packed {
		dwrr_pkg::status_t st;
		logic [6:0]        tag;
		logic [1:0]        cls;
		logic [31:0]       hnd;
	} outcome_t;

	// expected results, written at accept, read at the result strobe
	outcome_t    exp_mem[XD];
	int          wr_cnt = 0;
	int          rd_cnt = 0;
	logic [6:0]  slot_tag[NC][QD];
	logic [31:0] slot_hnd[NC][QD];
	int          head[NC];
	int          cnt[NC];
	int          credit[NC];
	int          cursor;
	logic [6:0]  tag_next;
	logic        live[NT];
	logic        inflight[NT];
	logic [1:0]  fl_cls[NT];
	logic [31:0] fl_hnd[NT];
	int          fl_count;
	int          weight[NC];
	int          limit;

	assign pending = wr_cnt - rd_cnt;

	// deficit round robin pick; returns NC when nothing can be granted
	function automatic int pick_class();
		int  p;
		logic ready;
		ready = 1'b0;
		for (int i = 0; i < NC; i++)
			if (cnt[i] != 0 && credit[i] > 0) ready = 1'b1;
		if (!ready)
			for (int i = 0; i < NC; i++)
				credit[i] = (cnt[i] != 0) ? ((credit[i] + weight[i] > 255) ? 255 :
					credit[i] + weight[i]) : 0;
		for (int i = 0; i < NC; i++) begin
			p = cursor;
			cursor = (p + 1) % NC;
			if (cnt[p] == 0) begin
				credit[p] = 0;
				continue;
			end
			if (credit[p] == 0) continue;
			credit[p]--;
			return p;
		end
		return NC;
	endfunction

	function automatic outcome_t predict(dwrr_pkg::cmd_t c, logic [1:0] pri,
			logic [31:0] h, logic [6:0] dt);
		outcome_t o;
		int p;
		int any;
		o = '{dwrr_pkg::ST_NONE, 7'd0, 2'd0, 32'd0};
		case (c)
			dwrr_pkg::CMD_ENQ: begin
				if (cnt[pri] >= QD) o.st = dwrr_pkg::ST_FULL;
				else if (live[tag_next]) o.st = dwrr_pkg::ST_TAG_BUSY;
				else begin
					slot_tag[pri][(head[pri] + cnt[pri]) % QD] = tag_next;
					slot_hnd[pri][(head[pri] + cnt[pri]) % QD] = h;
					cnt[pri]++;
					live[tag_next] = 1'b1;
					o.st = dwrr_pkg::ST_OK;
					o.tag = tag_next;
					tag_next = tag_next + 7'd1;
				end
			end
			dwrr_pkg::CMD_DISP: begin
				any = 0;
				for (int i = 0; i < NC; i++) if (cnt[i] != 0) any = 1;
				if (fl_count < limit && any != 0) begin
					p = pick_class();
					if (p < NC) begin
						o.st = dwrr_pkg::ST_OK;
						o.tag = slot_tag[p][head[p]];
						o.cls = p[1:0];
						o.hnd = slot_hnd[p][head[p]];
						head[p] = (head[p] + 1) % QD;
						cnt[p]--;
						if (cnt[p] == 0) credit[p] = 0;
						inflight[o.tag] = 1'b1;
						fl_cls[o.tag] = o.cls;
						fl_hnd[o.tag] = o.hnd;
						fl_count++;
					end
				end
			end
			dwrr_pkg::CMD_DONE: begin
				if (inflight[dt]) begin
					inflight[dt] = 1'b0;
					live[dt] = 1'b0;
					if (fl_count > 0) fl_count--;
					o = '{dwrr_pkg::ST_OK, dt, fl_cls[dt], fl_hnd[dt]};
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t e;
		if (!arst_n) begin
			wr_cnt = 0;
			rd_cnt = 0;
			fail_count <= 0;
			for (int i = 0; i < NC; i++) begin
				head[i] = 0; cnt[i] = 0; credit[i] = 0; weight[i] = 1;
			end
			for (int i = 0; i < NT; i++) begin
				live[i] = 1'b0; inflight[i] = 1'b0;
			end
			cursor = 0; tag_next = '0; fl_count = 0; limit = 8;
		end else begin
			if (done) begin
				if (wr_cnt == rd_cnt) begin
					if (fail_count < 10)
						$display("%0t: result with nothing expected: st=%0d tag=%0d",
							$realtime, status, out_tag);
					fail_count <= fail_count + 1;
				end else begin
					e = exp_mem[rd_cnt % XD];
					rd_cnt++;
					if (e.st !== status || e.tag !== out_tag || e.cls !== out_class
							|| e.hnd !== out_handle) begin
						if (fail_count < 10)
							$display("%0t: exp %0d/%0d/%0d/%h, got %0d/%0d/%0d/%h",
								$realtime, e.st, e.tag, e.cls, e.hnd,
								status, out_tag, out_class, out_handle);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) begin
				exp_mem[wr_cnt % XD] = predict(dwrr_pkg::cmd_t'(cmd), req_priority,
					req_handle, done_tag);
				wr_cnt++;
			end
			if (cfg_we) begin
				if (cfg_index < dwrr_pkg::REG_MAX_INFLIGHT) weight[cfg_index] = cfg_data;
				else if (cfg_index == dwrr_pkg::REG_MAX_INFLIGHT) limit = cfg_data[6:0];
			end
		end
	end
endmodule
`default_nettype wire

@@ tb/deficit_rr_priority_dispatcher_tb.sv @@
// Testbench top: drives command and config traffic into the dispatcher and gives the verdict.
`timescale 1ns / 100ps
`default_nettype none
module deficit_rr_priority_dispatcher_tb;

	localparam int WATCHDOG = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  cmd = '0;
	logic [1:0]  req_priority = '0;
	logic [31:0] req_handle = '0;
	logic [6:0]  done_tag = '0;
	logic        done;
	logic [1:0]  status;
	logic [6:0]  out_tag;
	logic [1:0]  out_class;
	logic [31:0] out_handle;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	int          fail_count;
	int          pending;
	int          idle_cycles = 0;
	int          txn_count = 0;
	// tags handed out by grants, so completions mostly hit live ones
	logic [6:0]  granted_tags[$];

	always #10 clk = ~clk;

	deficit_rr_priority_dispatcher dut (.*);

	deficit_rr_priority_dispatcher_checker u_checker (.*);

	// grab granted tags off the result port
	logic        last_was_disp;
	always @(posedge clk) begin
		if (start && !busy) last_was_disp <= (cmd == dwrr_pkg::CMD_DISP);
		if (done && last_was_disp && status == dwrr_pkg::ST_OK)
			granted_tags = {granted_tags, out_tag};
	end

	// watchdog: cycles with no accepted transaction
	always @(posedge clk) begin
		if (start && !busy) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("deficit_rr_priority_dispatcher: mismatch");
			$finish;
		end
	end

	// one transaction: hold start until the block takes it; start is dropped
	// by gap() or drain(), so back-to-back calls keep it high
	task automatic issue(dwrr_pkg::cmd_t c, logic [1:0] pri, logic [31:0] h,
			logic [6:0] t);
		start <= 1'b1;
		cfg_we <= 1'b0;
		cmd <= c;
		req_priority <= pri;
		req_handle <= h;
		done_tag <= t;
		@(posedge clk);
		while (busy) @(posedge clk);
		txn_count++;
	endtask

	// random gap, mostly short and sometimes long
	task automatic gap();
		int n;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) :
			(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3));
		if (n != 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// let everything drain before touching config
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// write enable stays high through back-to-back writes; issue() drops it
	task automatic write_reg(int idx, logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx[2:0];
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic random_cfg(int phase);
		for (int i = 0; i < 4; i++)
			write_reg(dwrr_pkg::REG_WEIGHT0 + i, (phase == 0) ? 8'd255 :
				(phase == 1) ? 8'd0 : 8'($urandom_range(0, 6)));
		write_reg(dwrr_pkg::REG_MAX_INFLIGHT, (phase == 0) ? 8'd64 : (phase == 1) ? 8'd1 :
			8'($urandom_range(1, 64)));
	endtask

	task automatic random_item();
		int r;
		logic [6:0] t;
		r = $urandom_range(0, 99);
		if (r < 45)
			issue(dwrr_pkg::CMD_ENQ, 2'($urandom_range(0, 3)), $urandom, '0);
		else if (r < 75)
			issue(dwrr_pkg::CMD_DISP, 2'($urandom), $urandom, 7'($urandom));
		else if (r < 95) begin
			if (granted_tags.size() != 0 && $urandom_range(0, 4) != 0) begin
				int k;
				k = $urandom_range(0, granted_tags.size() - 1);
				t = granted_tags[k];
				granted_tags.delete(k);
			end else t = 7'($urandom);
			issue(dwrr_pkg::CMD_DONE, 2'($urandom), $urandom, t);
		end else
			issue(dwrr_pkg::CMD_NOP, 2'($urandom), $urandom, 7'($urandom));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset weights, fill one class past full, extremes, nop, bad completion
		issue(dwrr_pkg::CMD_DISP, 2'd0, '0, '0);            // all queues empty
		issue(dwrr_pkg::CMD_DONE, 2'd0, '0, 7'd127);        // unknown tag
		issue(dwrr_pkg::CMD_NOP, 2'd3, 32'hFFFF_FFFF, 7'd127);
		for (int i = 0; i < 17; i++)               // last one hits a full queue
			issue(dwrr_pkg::CMD_ENQ, 2'd3, (i[0]) ? 32'hFFFF_FFFF : 32'h0, '0);
		issue(dwrr_pkg::CMD_ENQ, 2'd0, 32'hA5A5_5A5A, '0);
		for (int i = 0; i < 4; i++) issue(dwrr_pkg::CMD_DISP, 2'd0, '0, '0);
		drain();

		// phases: extreme weights and limits, then random settings
		for (int ph = 0; ph < 8; ph++) begin
			random_cfg(ph);
			for (int i = 0; i < 185; i++) begin
				random_item();
				gap();
			end
			// sender holds off until every result is in
			drain();
		end
		// tag-busy case: stall tags by granting without completing, then wrap tags
		write_reg(dwrr_pkg::REG_MAX_INFLIGHT, 8'd64);
		for (int i = 0; i < 4; i++) write_reg(dwrr_pkg::REG_WEIGHT0 + i, 8'd2);
		for (int i = 0; i < 140; i++) begin
			issue(($urandom_range(0, 1) != 0) ? dwrr_pkg::CMD_ENQ : dwrr_pkg::CMD_DISP,
				2'($urandom_range(0, 3)), $urandom, '0);
		end
		drain();

		$display("Covered %0d transactions across 9 register settings, incl. weight 0/255",
			txn_count);
		$display("and in-flight limits 1 and 64, full queues, busy tags and unknown completions.");
		if (fail_count == 0)
			$display("deficit_rr_priority_dispatcher: match");
		else
			$display("deficit_rr_priority_dispatcher: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
